// ===== rtl/mpool_pkg.sv =====
// Shared constants and types for the 3x3 stride-2 max-pooling core.
package mpool_pkg;

    // Window geometry
    localparam int WINDOW = 3;
    localparam int STRIDE = 2;

    // Configuration register map
    localparam int           MAP_SIZE_W     = 7;
    localparam int           APB_ADDR_W     = 2;
    localparam int           APB_DATA_W     = 32;
    localparam logic [APB_ADDR_W-1:0] REG_MAP_SIZE = 2'd0;
    localparam logic [MAP_SIZE_W-1:0] MAP_SIZE_RESET = 7'd55;

    // Per-cycle control for each cell of the partial-max line; shift is shared by all
    typedef struct packed {
        logic shift;   // line advances by one cell
        logic head;    // this cell takes the new value rather than its neighbour's
    } t_cell_ctrl;

endpackage

// ===== rtl/mpool_cell.sv =====
// One cell of the partial-maximum line: holds one column's vertical running maximum.
module mpool_cell
    import mpool_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  t_cell_ctrl                   i_ctrl,
    input  logic signed [DATA_WIDTH-1:0] i_left,
    input  logic signed [DATA_WIDTH-1:0] i_new,
    output logic signed [DATA_WIDTH-1:0] o_value
);

    logic signed [DATA_WIDTH-1:0] r_value;
    logic signed [DATA_WIDTH-1:0] n_value;

    always_comb begin
        n_value = i_ctrl.head ? i_new : i_left;
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/mpool_line.sv =====
// Chain of partial-maximum cells; the insertion point follows the output count per row.
module mpool_line
    import mpool_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int OUT_MAX    = 31,
    localparam int OW        = $clog2(OUT_MAX + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic [OW-1:0]                i_outs,
    input  logic signed [DATA_WIDTH-1:0] i_new,
    output logic signed [DATA_WIDTH-1:0] o_tail
);

    logic signed [DATA_WIDTH-1:0] w_val [OUT_MAX];

    for (genvar k = 0; k < OUT_MAX; k++) begin : g_cell
        t_cell_ctrl                   w_ctrl;
        logic signed [DATA_WIDTH-1:0] w_left;

        // head sits outs cells from the tail, so an entry returns after one row
        assign w_ctrl.shift = i_shift;
        assign w_ctrl.head  = (32'(i_outs) == 32'(OUT_MAX - k));

        if (k == 0) begin : g_first
            assign w_left = i_new;
        end else begin : g_rest
            assign w_left = w_val[k-1];
        end

        mpool_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_new   (i_new),
            .o_value (w_val[k])
        );
    end

    assign o_tail = w_val[OUT_MAX-1];

endmodule

// ===== rtl/max_pool_3x3_stride2_core.sv =====
// Top level of the streaming 3x3 stride-2 max-pooling core with APB size register.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------
//  input   | i_in_valid  | o_in_ready  | i_pixel_value
//  output  | o_out_valid | i_out_ready | o_pooled_value, o_plane_last
//  config  | psel/penable/pwrite (APB) | pready=1 | paddr, pwdata, prdata
//
// One input request is taken per cycle while o_in_ready is high; its window result,
// if any, is registered into the output register, or into the skid entry behind it.
// A two-entry output buffer (main register plus skid) keeps input flowing while
// a result waits; o_in_ready drops only when both entries are full.
// Synchronous active-low reset clears counters, hold and buffer valids and sets
// map_size to 55. The partial-maximum line has no reset: row 0 of every plane
// writes each column before any read.
// Writing map_size restarts the plane at row 0, column 0.
module max_pool_3x3_stride2_core
    import mpool_pkg::*;
#(
    parameter int MAX_SIZE   = 64,
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_pixel_value,
    // result stream
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_pooled_value,
    output logic                         o_plane_last,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int OUT_MAX = (MAX_SIZE - WINDOW) / STRIDE + 1;
    localparam int CW      = $clog2(MAX_SIZE);       // column / row index
    localparam int SW      = $clog2(MAX_SIZE + 1);   // clamped side length
    localparam int OW      = $clog2(OUT_MAX + 1);    // outputs per side

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [MAP_SIZE_W-1:0] r_map_size;
    logic                  w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == REG_MAP_SIZE);

    always_comb begin
        prdata = '0;
        if (paddr == REG_MAP_SIZE) begin
            prdata = APB_DATA_W'(r_map_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size <= MAP_SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_map_size <= pwdata[MAP_SIZE_W-1:0];
        end
    end

    // clamp the side to [3, MAX_SIZE]
    logic [SW-1:0] w_size;
    logic [SW-1:0] w_last_pos;  // row/col of the final window's right/bottom edge
    logic [OW-1:0] w_outs;

    always_comb begin
        if (32'(r_map_size) < 32'(WINDOW)) begin
            w_size = SW'(WINDOW);
        end else if (32'(r_map_size) > 32'(MAX_SIZE)) begin
            w_size = SW'(MAX_SIZE);
        end else begin
            w_size = SW'(r_map_size);
        end
    end

    // outs = (size-1)/2; last window edge = 2*outs
    assign w_outs     = OW'((w_size - SW'(1)) >> 1);
    assign w_last_pos = (w_size - SW'(1)) & ~SW'(1);

    // ---------------------------------------------------------------
    // Scan position and horizontal maximum
    // ---------------------------------------------------------------
    logic [CW-1:0]                r_col;
    logic [CW-1:0]                r_row;
    logic signed [DATA_WIDTH-1:0] r_hold;
    logic [CW-1:0]                n_col;
    logic [CW-1:0]                n_row;
    logic signed [DATA_WIDTH-1:0] n_hold;

    logic                         w_accept;
    logic                         w_col_end;
    logic                         w_row_end;
    logic                         w_event;     // even column past 0: one window row done
    logic signed [DATA_WIDTH-1:0] w_hmax;
    logic signed [DATA_WIDTH-1:0] w_tail;
    logic signed [DATA_WIDTH-1:0] w_line_new;
    logic signed [DATA_WIDTH-1:0] w_res_data;
    logic                         w_res_last;
    logic                         w_produce;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_col_end = (SW'(r_col) == w_size - SW'(1));
    assign w_row_end = (SW'(r_row) == w_size - SW'(1));
    assign w_event   = w_accept && !r_col[0] && (r_col != '0);
    assign w_hmax    = (r_hold > i_pixel_value) ? r_hold : i_pixel_value;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_col_end) begin
            n_col = '0;
            n_row = w_row_end ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end

        if (r_col == '0) begin
            n_hold = i_pixel_value;
        end else if (r_col[0]) begin
            n_hold = w_hmax;
        end else begin
            n_hold = i_pixel_value;   // shared column starts the next window row
        end
    end

    // vertical update: row 0 seeds, odd rows fold in, even rows close windows and reseed
    always_comb begin
        w_line_new = w_hmax;
        w_produce  = 1'b0;
        w_res_data = (w_tail > w_hmax) ? w_tail : w_hmax;
        w_res_last = (SW'(r_row) == w_last_pos) && (SW'(r_col) == w_last_pos);
        if (r_row == '0) begin
            w_line_new = w_hmax;
        end else if (r_row[0]) begin
            w_line_new = (w_hmax > w_tail) ? w_hmax : w_tail;
        end else begin
            w_line_new = w_hmax;
            w_produce  = w_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_wr) begin
            r_col  <= '0;
            r_row  <= '0;
            r_hold <= '0;
        end else if (w_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_hold <= n_hold;
        end
    end

    mpool_line #(
        .DATA_WIDTH (DATA_WIDTH),
        .OUT_MAX    (OUT_MAX)
    ) u_line (
        .i_clk   (i_clk),
        .i_shift (w_event),
        .i_outs  (w_outs),
        .i_new   (w_line_new),
        .o_tail  (w_tail)
    );

    // ---------------------------------------------------------------
    // Output register plus skid entry
    // ---------------------------------------------------------------
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_data;
    logic                         r_out_last;
    logic                         r_skid_valid;
    logic signed [DATA_WIDTH-1:0] r_skid_data;
    logic                         r_skid_last;
    logic                         w_pop;

    assign w_pop      = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
                r_out_data   <= r_skid_data;
                r_out_last   <= r_skid_last;
            end else begin
                r_out_valid <= w_produce;
                r_out_data  <= w_res_data;
                r_out_last  <= w_res_last;
            end
        end else if (w_produce) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_res_data;
                r_out_last  <= w_res_last;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= w_res_data;
                r_skid_last  <= w_res_last;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pooled_value = r_out_data;
    assign o_plane_last   = r_out_last;

`ifndef SYNTHESIS
    // skid only fills behind a held main entry
    a_skid_behind_main : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // scan position stays inside the plane
    a_pos_in_plane : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_col) < w_size) && (SW'(r_row) < w_size))
        else $error("scan position outside plane");

    // a stalled full buffer must not lose its main entry
    a_full_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_ready) |=> (r_out_valid && r_skid_valid))
        else $error("output buffer dropped a request while stalled");
`endif

endmodule

// ===== verif/pool_window_checker.sv =====
// Checker for the 3x3 stride-2 max-pooling core: predicts each window maximum and compares.
module pool_window_checker
    import mpool_pkg::*;
#(
    parameter int MAX_SIDE = 64,
    parameter int PIX_W    = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [PIX_W-1:0] i_pixel_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [PIX_W-1:0] i_pooled_value,
    input  logic                    i_plane_last,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    input  logic                    pready,
    output int                      o_mismatches,
    output int                      o_windows_due
);

    localparam int LINE_DEPTH = (MAX_SIDE - WINDOW) / STRIDE + 1;

    typedef struct packed {
        logic signed [PIX_W-1:0] value;
        logic                    last;
    } t_window;

    logic [MAP_SIZE_W-1:0]   side_reg;
    logic [5:0]              col_pos;
    logic [5:0]              row_pos;
    logic signed [PIX_W-1:0] row_hold;
    logic signed [PIX_W-1:0] col_max [LINE_DEPTH];
    t_window                 windows_due [$];
    int                      mismatch_count;

    // One pixel through the pooling predictor; returns 1 when it closes a window.
    function automatic bit predict_window(input logic signed [PIX_W-1:0] px,
                                          output t_window res);
        int                      side;
        int                      outs;
        int                      j;
        int                      i;
        logic signed [PIX_W-1:0] h;
        logic signed [PIX_W-1:0] m;
        bit                      hit;
        hit  = 1'b0;
        res  = '0;
        side = (side_reg < WINDOW) ? WINDOW : (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
        outs = (side - WINDOW) / STRIDE + 1;
        if (col_pos == 0) begin
            row_hold = px;
        end else if (col_pos[0]) begin
            if (px > row_hold) row_hold = px;
        end else begin
            j        = (int'(col_pos) - 2) / 2;
            h        = (row_hold > px) ? row_hold : px;
            row_hold = px;      // even column is shared with the next window
            if (j < outs) begin
                if (row_pos == 0) begin
                    col_max[j] = h;
                end else if (row_pos[0]) begin
                    if (h > col_max[j]) col_max[j] = h;
                end else begin
                    i          = (int'(row_pos) - 2) / 2;
                    m          = (col_max[j] > h) ? col_max[j] : h;
                    col_max[j] = h;     // even row opens the next window row
                    if (i < outs) begin
                        hit       = 1'b1;
                        res.value = m;
                        res.last  = (i == outs - 1) && (j == outs - 1);
                    end
                end
            end
        end
        if (int'(col_pos) + 1 >= side) begin
            col_pos = '0;
            row_pos = (int'(row_pos) + 1 >= side) ? '0 : row_pos + 6'd1;
        end else begin
            col_pos = col_pos + 6'd1;
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        t_window want;
        t_window got;
        if (!i_rst_n) begin
            side_reg       = MAP_SIZE_RESET;
            col_pos        = '0;
            row_pos        = '0;
            row_hold       = '0;
            mismatch_count = 0;
            windows_due.delete();
            foreach (col_max[k]) col_max[k] = '0;
        end else begin
            // results first: they always belong to requests taken earlier
            if (i_out_valid && i_out_ready) begin
                if (windows_due.size() == 0) begin
                    $display("%0t: result with nothing due: value %0d last %0b",
                             $time, i_pooled_value, i_plane_last);
                    mismatch_count++;
                end else begin
                    want = windows_due.pop_front();
                    if (i_pooled_value !== want.value) begin
                        $display("%0t: pooled_value expected %0d, got %0d",
                                 $time, want.value, i_pooled_value);
                        mismatch_count++;
                    end
                    if (i_plane_last !== want.last) begin
                        $display("%0t: plane_last expected %0b, got %0b",
                                 $time, want.last, i_plane_last);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (predict_window(i_pixel_value, got)) windows_due.push_back(got);
            end
            if (psel && penable && pwrite && pready && paddr == REG_MAP_SIZE) begin
                side_reg = pwdata[MAP_SIZE_W-1:0];
                col_pos  = '0;
                row_pos  = '0;
                row_hold = '0;
            end
        end
        o_mismatches  <= mismatch_count;
        o_windows_due <= windows_due.size();
    end

endmodule

// ===== verif/max_pool_3x3_stride2_core_test.sv =====
// Stimulus and verdict for the max_pool_3x3_stride2_core block.
module max_pool_3x3_stride2_core_test;
    import mpool_pkg::*;

    localparam int PIX_W         = 16;
    localparam int RANDOM_TARGET = 1000;     // random requests to send, roughly
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_LIMIT   = 10_000;
    localparam int SETTLE_CYCLES = 4;        // output register plus the skid entry, with margin

    typedef enum int {PIX_WIDE, PIX_TIES, PIX_EDGES} t_pixel_style;

    // Directed 3x3 planes: all minimum, peak in the last corner, peak in the first
    localparam logic signed [PIX_W-1:0] FLOOR_PLANE [9] = '{
        16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    localparam logic signed [PIX_W-1:0] LATE_PEAK_PLANE [9] = '{
        -16'sd1, 16'sd0, 16'sh8000, 16'sd1, 16'sh8000,
        -16'sd2, 16'sh8000, 16'sh8000, 16'sh7fff};
    localparam logic signed [PIX_W-1:0] EARLY_PEAK_PLANE [9] = '{
        16'sh7fff, 16'sh7ffe, -16'sd1, 16'sd0, 16'sh5555,
        16'shaaaa, 16'sh7ffe, 16'sh8000, 16'sh0001};

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic signed [PIX_W-1:0]   i_pixel_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [PIX_W-1:0]   o_pooled_value;
    logic                      o_plane_last;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]     pwdata;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    int mismatches;
    int windows_due;
    int idle_pct    = 0;    // percent chance of an idle burst per request; a third of it per result slot
    int stall_left  = 0;
    int cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    max_pool_3x3_stride2_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_value  (i_pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pooled_value (o_pooled_value),
        .o_plane_last   (o_plane_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    pool_window_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_pixel_value  (i_pixel_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_pooled_value (o_pooled_value),
        .i_plane_last   (o_plane_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_mismatches   (mismatches),
        .o_windows_due  (windows_due)
    );

    // Hard stop, well above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("max_pool_3x3_stride2_core_test failed");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts, none while idle_pct is zero.
    always @(posedge i_clk) begin
        if (idle_pct == 0) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(99) < idle_pct / 3) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(11);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic signed [PIX_W-1:0] pick_pixel(input t_pixel_style style);
        case (style)
            PIX_TIES: begin
                // narrow spread, so equal values meet in the same window
                return PIX_W'($urandom_range(6)) - PIX_W'(3);
            end
            PIX_EDGES: begin
                case ($urandom_range(3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return -16'sd1;
                    default: return PIX_W'($urandom);
                endcase
            end
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // One input request; an idle burst may go before it.
    task automatic feed_pixel(input logic signed [PIX_W-1:0] px);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_value <= px;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and hold off until every predicted window has been taken.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (windows_due != 0);
    endtask

    // Size writes only with the core idle; upper data bits are noise the core must ignore.
    task automatic write_map_size(input logic [MAP_SIZE_W-1:0] size);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAP_SIZE;
        pwdata  <= {(APB_DATA_W - MAP_SIZE_W)'($urandom), size};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic feed_run(input int count, input t_pixel_style style);
        repeat (count) begin
            // now and then let the core empty out mid-plane
            if ($urandom_range(399) == 0) hold_until_drained();
            feed_pixel(pick_pixel(style));
        end
    endtask

    initial begin
        int                    fed;
        int                    pick;
        int                    side;
        int                    count;
        int                    waited;
        logic [MAP_SIZE_W-1:0] code;
        t_pixel_style          style;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_pixel_value <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size of 55: three rows plus a bit give the first row of windows.
        idle_pct = 10;
        feed_run(3 * 55 + 20, PIX_WIDE);

        // Directed 3x3 planes, written with sizes below range so they act as 3.
        idle_pct = 0;
        write_map_size(7'd0);
        foreach (FLOOR_PLANE[k]) feed_pixel(FLOOR_PLANE[k]);
        write_map_size(7'd2);
        foreach (LATE_PEAK_PLANE[k]) feed_pixel(LATE_PEAK_PLANE[k]);
        write_map_size(7'd1);
        foreach (EARLY_PEAK_PLANE[k]) feed_pixel(EARLY_PEAK_PLANE[k]);

        // Several rows at the largest size, with a forced drain part-way.
        idle_pct = 5;
        write_map_size(7'd64);
        feed_run(3 * 64 + 20, PIX_WIDE);
        hold_until_drained();
        feed_run(2 * 64 + 10, PIX_EDGES);

        // Random phases: mostly small planes, some mid and out-of-range sizes,
        // often ending mid-plane so the next size write restarts a live plane.
        fed = 0;
        while (fed < RANDOM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 65)      code = MAP_SIZE_W'($urandom_range(12, 3));
            else if (pick < 80) code = MAP_SIZE_W'($urandom_range(63, 13));
            else if (pick < 88) code = MAP_SIZE_W'($urandom_range(2));
            else if (pick < 95) code = MAP_SIZE_W'($urandom_range(127, 65));
            else                code = 7'd64;
            side = (code < 3) ? 3 : (code > 64) ? 64 : code;

            case ($urandom_range(2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 30;
            endcase
            style = t_pixel_style'($urandom_range(2));

            if (side <= 12) count = $urandom_range(4, 1) * side * side;
            else            count = side * $urandom_range(8, 3);
            if ($urandom_range(1) == 1) count += $urandom_range(2 * side, 1);

            write_map_size(code);
            feed_run(count, style);
            fed += count;
        end

        // Closing stretch with no idling on either side.
        idle_pct = 0;
        write_map_size(7'd5);
        feed_run(2 * 25 + 7, PIX_WIDE);
        write_map_size(7'd3);
        feed_run(3 * 9, PIX_TIES);

        i_in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (windows_due != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && windows_due == 0) begin
            $display("max_pool_3x3_stride2_core_test passed");
        end else begin
            $display("max_pool_3x3_stride2_core_test failed");
        end
        $finish;
    end

endmodule
